>>> design/shef_pkg.sv
// Shared types and constants for the horizontal Sobel edge filter.
// No dependencies; every other file of the block imports this package.
package shef_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int PIX_W       = 8;
   localparam int POS_W       = 9;
   localparam int DIM_W       = 10;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = DIM_W'(512);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic [PIX_W-1:0] edge_value;
      logic             frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_info_type;

   typedef struct packed {
      logic [PIX_W-1:0] two_back;
      logic [PIX_W-1:0] one_back;
   } line_word_type;

endpackage

>>> design/shef_line_store.sv
// Line store: both previous image rows side by side in one synchronous memory.
// Registered read; a read of the address being written returns the new data. Uses shef_pkg.
module shef_line_store
   import shef_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output line_word_type rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_word_type wr_data
);

   line_word_type mem [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/shef_scan_ctrl.sv
// Scan control: image size registers, row and column counters, interior test.
// Gives the line store address and position info of the current pixel. Uses shef_pkg.
module shef_scan_ctrl
   import shef_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CW         = $clog2(MAX_WIDTH_DEF)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_wdata,
   input  logic                   advance,
   input  logic                   frame_start,
   output logic [CW-1:0]          cur_col,
   output pos_info_type           pos_info
);

   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int EWW = $clog2(MAX_WIDTH + 1);
   localparam int EWH = $clog2(MAX_HEIGHT + 1);
   localparam int SW0 = (EWW > EWH) ? EWW : EWH;
   localparam int SW  = (SW0 > DIM_W) ? SW0 : DIM_W;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CW-1:0]    col_ff, col_in, c;
   logic [RW-1:0]    row_ff, row_in, r;
   logic [SW-1:0]    eff_w, eff_h, ce, re, row_m1, col_m1;
   logic             col_last, row_last;

   function automatic logic [SW-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                             input logic [SW-1:0] hi);
      logic [SW-1:0] ve;
      ve = SW'(v);
      if (ve < SW'(3)) begin
         return SW'(3);
      end else if (ve > hi) begin
         return hi;
      end
      return ve;
   endfunction

   always_comb begin
      eff_w    = sat_dim(width_ff, SW'(MAX_WIDTH));
      eff_h    = sat_dim(height_ff, SW'(MAX_HEIGHT));
      c        = frame_start ? '0 : col_ff;
      r        = frame_start ? '0 : row_ff;
      ce       = SW'(c);
      re       = SW'(r);
      col_last = (ce + SW'(1)) >= eff_w;
      row_last = (re + SW'(1)) >= eff_h;
      row_m1   = re - SW'(1);
      col_m1   = ce - SW'(1);

      pos_info.emit = (re >= SW'(2)) && (ce >= SW'(2)) && (re < eff_h) && (ce < eff_w);
      pos_info.last = row_last && col_last;
      pos_info.row  = row_m1[POS_W-1:0];
      pos_info.col  = col_m1[POS_W-1:0];

      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : r + RW'(1);
      end else begin
         col_in = c + CW'(1);
         row_in = r;
      end
   end

   assign cur_col = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_DIM_RESET;
         height_ff <= IMAGE_DIM_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (advance) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

>>> design/shef_kernel.sv
// Sobel kernel: top and bottom 3-pixel windows, weighted row sums, clamp.
// Window shifts on each pixel leaving the read stage. Uses shef_pkg.
module shef_kernel
   import shef_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [PIX_W-1:0] top_px,
   input  logic [PIX_W-1:0] bot_px,
   output logic [PIX_W-1:0] edge_value
);

   localparam int SUM_W = PIX_W + 2;

   logic [PIX_W-1:0]   top_ff [2];
   logic [PIX_W-1:0]   bot_ff [2];
   logic [SUM_W-1:0]   top_sum, bot_sum;
   logic signed [SUM_W:0] diff;

   always_comb begin
      top_sum = SUM_W'(top_ff[0]) + {1'b0, top_ff[1], 1'b0} + SUM_W'(top_px);
      bot_sum = SUM_W'(bot_ff[0]) + {1'b0, bot_ff[1], 1'b0} + SUM_W'(bot_px);
      diff    = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
      if (diff < 0) begin
         edge_value = '0;
      end else if (diff > $signed((SUM_W+1)'(255))) begin
         edge_value = '1;
      end else begin
         edge_value = diff[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '{default: '0};
         bot_ff <= '{default: '0};
      end else if (shift_en) begin
         top_ff[0] <= top_ff[1];
         top_ff[1] <= top_px;
         bot_ff[0] <= bot_ff[1];
         bot_ff[1] <= bot_px;
      end
   end

endmodule

>>> design/sobel_horizontal_edge_filter.sv
// Horizontal 3x3 Sobel edge filter over a row-major 8-bit grayscale pixel stream.
// Depends on shef_pkg, shef_scan_ctrl, shef_line_store and shef_kernel.
//
// Usage:
//   req_* carries one pixel per transaction; set frame_start on row 0, column 0.
//   rsp_* carries one result per interior pixel (row and column 1..size-2):
//   the top row weighted 1,2,1 minus the bottom row weighted 1,2,1, clamped
//   to 0..255. Border pixels produce no transaction.
//   csr_* writes image_width (index 0) and image_height (index 1); write only
//   while the block is idle. Sizes saturate to 3..MAX_WIDTH / 3..MAX_HEIGHT.
// Throughput and pipeline:
//   One pixel per clock sustained while the output is not stalled. The pixel
//   that completes a window passes through the read stage, where the line
//   store is read, and the kernel result then goes into the output register.
// Reset:
//   Synchronous, active high; clears counters, windows, pipeline valids and
//   sets both sizes to 512. The line store is not cleared.
// Stall:
//   A stalled result holds; the read stage keeps running while its pixel
//   needs no output slot, otherwise req_stall rises in the same cycle.
module sobel_horizontal_edge_filter
   import shef_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic            accept, out_free, s1_adv;
   logic [CW-1:0]   cur_col;
   pos_info_type    pos_info;
   line_word_type   rd_data, wr_data;
   logic [PIX_W-1:0] edge_value;

   logic             s1_valid_ff, s1_valid_in;
   pos_info_type     s1_info_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (out_free || !s1_info_ff.emit);
   assign req_stall = s1_valid_ff && !s1_adv;

   assign wr_data.two_back = rd_data.one_back;
   assign wr_data.one_back = s1_pixel_ff;

   shef_scan_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW)
   ) u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .advance     (accept),
      .frame_start (req_payload.frame_start),
      .cur_col     (cur_col),
      .pos_info    (pos_info)
   );

   shef_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   shef_kernel u_kernel (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_adv),
      .top_px     (rd_data.two_back),
      .bot_px     (s1_pixel_ff),
      .edge_value (edge_value)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_info_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_info_ff  <= pos_info;
         s1_col_ff   <= cur_col;
         s1_pixel_ff <= req_payload.pixel;
      end
      if (s1_adv && s1_info_ff.emit) begin
         rsp_payload_ff.out_row    <= s1_info_ff.row;
         rsp_payload_ff.out_col    <= s1_info_ff.col;
         rsp_payload_ff.edge_value <= edge_value;
         rsp_payload_ff.frame_last <= s1_info_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> design/shef_checker.sv
// Port-level checks for sobel_horizontal_edge_filter, attached by bind.
// Depends on shef_pkg and the top level's ports.
module shef_checker
   import shef_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty output slot never backs up the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with free output");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without accepted pixel");

endmodule

bind sobel_horizontal_edge_filter shef_checker u_shef_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> tb/shef_edge_check_pkg.sv
// Scoreboard for the horizontal Sobel edge filter testbench: predicts each result
// from the accepted pixels and checks the results that leave the block.
// Depends on shef_pkg for the payload types, sizes and register indexes.
package shef_edge_check_pkg;
   import shef_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   class edge_scoreboard;
      logic [PIX_W-1:0] older_line [MAX_WIDTH_DEF];
      logic [PIX_W-1:0] newer_line [MAX_WIDTH_DEF];
      logic [PIX_W-1:0] upper_taps [3];
      logic [PIX_W-1:0] lower_taps [3];
      int unsigned      row_pos;
      int unsigned      col_pos;
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      rsp_payload_type  expected_edges [$];
      int unsigned      mismatches;

      function new();
         foreach (older_line[i]) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
         foreach (upper_taps[i]) begin
            upper_taps[i] = '0;
            lower_taps[i] = '0;
         end
         row_pos    = 0;
         col_pos    = 0;
         width_reg  = IMAGE_DIM_RESET;
         height_reg = IMAGE_DIM_RESET;
         mismatches = 0;
      endfunction

      function int unsigned clamp_dim(input logic [DIM_W-1:0] value, input int unsigned hi);
         if (value < 3) return 3;
         if (value > hi) return hi;
         return value;
      endfunction

      function int unsigned eff_width();
         return clamp_dim(width_reg, MAX_WIDTH_DEF);
      endfunction

      function int unsigned eff_height();
         return clamp_dim(height_reg, MAX_HEIGHT_DEF);
      endfunction

      function int unsigned waiting();
         return expected_edges.size();
      endfunction

      function bit failed();
         return mismatches != 0 || expected_edges.size() != 0;
      endfunction

      function void write_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [DIM_W-1:0] value);
         case (index)
            REG_IMAGE_WIDTH: begin
               width_reg = value;
            end
            REG_IMAGE_HEIGHT: begin
               height_reg = value;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_pixel(input req_payload_type item);
         int unsigned      w;
         int unsigned      h;
         int unsigned      r;
         int unsigned      c;
         int               upper_sum;
         int               lower_sum;
         int               diff;
         logic [PIX_W-1:0] above2;
         logic [PIX_W-1:0] above1;
         rsp_payload_type  due;
         w = eff_width();
         h = eff_height();
         if (item.frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = col_pos;
         above2 = older_line[c];
         above1 = newer_line[c];
         older_line[c] = above1;
         newer_line[c] = item.pixel;
         upper_taps[0] = upper_taps[1];
         upper_taps[1] = upper_taps[2];
         upper_taps[2] = above2;
         lower_taps[0] = lower_taps[1];
         lower_taps[1] = lower_taps[2];
         lower_taps[2] = item.pixel;
         if (r >= 2 && c >= 2 && r < h && c < w) begin
            upper_sum = int'(upper_taps[0]) + 2 * int'(upper_taps[1]) + int'(upper_taps[2]);
            lower_sum = int'(lower_taps[0]) + 2 * int'(lower_taps[1]) + int'(lower_taps[2]);
            diff = upper_sum - lower_sum;
            if (diff < 0) begin
               diff = 0;
            end else if (diff > 255) begin
               diff = 255;
            end
            due.out_row    = POS_W'(r - 1);
            due.out_col    = POS_W'(c - 1);
            due.edge_value = PIX_W'(diff);
            due.frame_last = (r + 1 >= h) && (c + 1 >= w);
            expected_edges.push_back(due);
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result: row %0d col %0d value %0d last %0b",
                        got.out_row, got.out_col, got.edge_value, got.frame_last);
            end
            return;
         end
         want = expected_edges.pop_front();
         if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
             got.edge_value !== want.edge_value || got.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("edge mismatch: want row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
                        want.out_row, want.out_col, want.edge_value, want.frame_last,
                        got.out_row, got.out_col, got.edge_value, got.frame_last);
            end
         end
      endfunction
   endclass

endpackage

>>> tb/sobel_horizontal_edge_filter_tb.sv
// Self-checking testbench for sobel_horizontal_edge_filter: directed frames, then
// random frames over many image sizes with random idle on both channels.
// Depends on shef_pkg and shef_edge_check_pkg.
module sobel_horizontal_edge_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shef_pkg::*;
   import shef_edge_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned ITEM_TARGET   = 1550;
   localparam int unsigned IDLE_PERCENT  = 24;
   localparam int unsigned QUIET_FIRST   = 600;
   localparam int unsigned QUIET_LAST    = 1000;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = CSR_INDEX_W'(3);

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [DIM_W-1:0]       csr_wdata   = '0;

   edge_scoreboard edges = new();
   int unsigned    pixels_sent = 0;
   int unsigned    cycle_count = 0;
   bit             no_idle     = 1'b0;

   sobel_horizontal_edge_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99, 0) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) edges.note_pixel(req_payload);
         if (rsp_valid && !rsp_stall) edges.check_result(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit start);
      if (!no_idle && $urandom_range(99, 0) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{pixel: pix, frame_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      no_idle = pixels_sent >= QUIET_FIRST && pixels_sent < QUIET_LAST;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (edges.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DIM_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      edges.write_register(index, value);
   endtask

   task automatic send_flat_frame(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
                                  input logic [PIX_W-1:0] bottom, input bit start);
      int k;
      for (k = 0; k < 9; k++) begin
         send_pixel(k < 3 ? top : (k < 6 ? mid : bottom), start && k == 0);
      end
   endtask

   task automatic run_phase(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                            input int unsigned frames);
      int unsigned old_w;
      int unsigned w;
      int unsigned h;
      int unsigned f;
      int unsigned k;
      int unsigned total;
      int unsigned pause_at;
      int          slope;
      int          level;
      int          base;
      bit          start;
      bit          ramp;
      bit          pause;
      bit          rough;
      settle();
      old_w = edges.eff_width();
      write_reg(REG_IMAGE_WIDTH, w_val);
      write_reg(REG_IMAGE_HEIGHT, h_val);
      if ($urandom_range(5, 0) == 0) begin
         write_reg($urandom_range(1, 0) ? REG_SPARE_LOW : REG_SPARE_HIGH, DIM_W'($urandom));
      end
      csr_we <= 1'b0;
      w = edges.eff_width();
      h = edges.eff_height();
      // a wider row past row 0 would read line store columns never written
      start = (edges.row_pos >= 1 && w > old_w) || $urandom_range(1, 0) != 0;
      for (f = 0; f < frames; f++) begin
         rough = f > 0;
         total = w * h;
         if (rough && $urandom_range(99, 0) < 30) total = $urandom_range(total - 1, 1);
         ramp     = $urandom_range(1, 0) != 0;
         base     = $urandom_range(255, 0);
         slope    = int'($urandom_range(80, 0)) - 40;
         pause    = $urandom_range(7, 0) == 0;
         pause_at = $urandom_range(total - 1, 0);
         if (f > 0) start = $urandom_range(99, 0) < 70;
         for (k = 0; k < total; k++) begin
            if (pause && k == pause_at) settle();
            if (ramp) begin
               level = base + slope * int'(k / w) + int'($urandom_range(6, 0)) - 3;
               if (level < 0) begin
                  level = 0;
               end else if (level > 255) begin
                  level = 255;
               end
            end else begin
               level = $urandom_range(255, 0);
            end
            send_pixel(PIX_W'(level), (start && k == 0) || (rough && $urandom_range(99, 0) == 0));
         end
      end
   endtask

   initial begin
      int unsigned      phase;
      logic [DIM_W-1:0] w_val;
      logic [DIM_W-1:0] h_val;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_SPARE_LOW, '1);
      write_reg(REG_SPARE_HIGH, DIM_W'(5));
      write_reg(REG_IMAGE_WIDTH, DIM_W'(0));
      write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
      csr_we <= 1'b0;
      send_flat_frame(8'hFF, 8'h80, 8'h00, 1'b1);
      send_flat_frame(8'h00, 8'h4D, 8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      settle();
      send_flat_frame(8'd100, 8'd1, 8'd70, 1'b1);

      for (phase = 0; phase < 3 || pixels_sent < ITEM_TARGET; phase++) begin
         if (phase == 1) begin
            run_phase(DIM_W'(1023), DIM_W'(3), 1);
         end else begin
            w_val = ($urandom_range(99, 0) < 15) ? DIM_W'($urandom_range(2, 0))
                                                 : DIM_W'($urandom_range(16, 3));
            h_val = ($urandom_range(99, 0) < 15) ? DIM_W'($urandom_range(2, 0))
                                                 : DIM_W'($urandom_range(8, 3));
            run_phase(w_val, h_val, $urandom_range(3, 1));
         end
      end

      settle();
      if (edges.failed()) begin
         $display("== FAIL ==");
      end else begin
         $display("== PASS ==");
      end
      $finish;
   end

endmodule

>>> sobel_horizontal_edge_filter.f
design/shef_pkg.sv
design/shef_line_store.sv
design/shef_scan_ctrl.sv
design/shef_kernel.sv
design/sobel_horizontal_edge_filter.sv
design/shef_checker.sv
tb/shef_edge_check_pkg.sv
tb/sobel_horizontal_edge_filter_tb.sv
